@@ rtl/ue_attach_paging_table_macros.svh @@
// Assertion macros for the terminal attach and paging context table.
`ifndef UE_ATTACH_PAGING_TABLE_MACROS_SVH
`define UE_ATTACH_PAGING_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UAPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("uapt assertion failed");

// Next-cycle implication, checked outside reset.
`define UAPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("uapt assertion failed");

`endif

@@ rtl/uapt_pkg.sv @@
// Package: types and constants of the terminal attach and paging context table.
package uapt_pkg;

    localparam int UE_COUNT  = 256;
    localparam int UE_IDX_W  = $clog2(UE_COUNT);
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 64;
    localparam int TMSI_W    = 49;
    localparam int SID_W     = 40;
    localparam int TMO_W     = 12;
    localparam int TIME_W    = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_TMSI_BASE_ADDR = 4'h0;
    localparam logic [TMSI_W-1:0] TMSI_BASE_RESET = 49'd452040000000001;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 12'd500;

    localparam logic [7:0] MSG_CONN_REQ  = 8'h10;
    localparam logic [7:0] MSG_CONN_RESP = 8'h11;
    localparam logic [7:0] MSG_PAGING    = 8'h15;
    localparam logic [7:0] BM_RAND       = 8'h01;
    localparam logic [7:0] BM_SHORT      = 8'h02;

    typedef enum logic [1:0] {
        ACT_INIT    = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_SERVICE = 2'd2,
        ACT_POLL    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_REG  = 2'd1,
        PH_CONN = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [7:0]       ue_index;
        logic             msg_valid;
        logic [7:0]       msg_id;
        logic [7:0]       msg_bitmask;
        logic [SID_W-1:0] msg_s_tmsi;
        logic [TMO_W-1:0] timeout_ms;
    } uapt_in_t;

    typedef struct packed {
        logic [7:0]        out_ue_index;
        logic [1:0]        ue_phase;
        logic              phase_changed;
        logic              request_valid;
        logic              request_reattach;
        logic [SID_W-1:0]  request_s_tmsi;
        logic [TMSI_W-1:0] request_tmsi;
    } uapt_out_t;

    typedef struct packed {
        phase_t            phase;
        logic [SID_W-1:0]  short_id;
        logic              pending;
        logic [TMO_W-1:0]  timeout;
        logic [TIME_W-1:0] deadline;
    } uapt_ctx_t;

    localparam uapt_ctx_t CTX_RESET = '{
        phase:    PH_IDLE,
        short_id: '0,
        pending:  1'b1,
        timeout:  TIMEOUT_RESET,
        deadline: '0
    };

endpackage

@@ rtl/ue_attach_paging_table.sv @@
// Terminal attach and paging context table: one context read-modify-write per beat,
// except that tick beats and out-of-range indices write no context.
// Input beats (s_valid/s_ready, s_data) carry an action and a terminal index:
// init loads the terminal's timeout, tick advances the saturating millisecond
// counter, service applies an optional downlink message and then the
// registered-to-idle timer, poll produces an attach request if idle and pending.
// Every input beat gives exactly one result beat on m_valid/m_ready, m_data.
// A beat accepted goes to the input register, and its result to the result
// register. Throughput: one beat per cycle while m_ready does not stall, set
// by the single read and single write port of the context memory; beats
// back-to-back to the same terminal are served by a one-entry write bypass.
// If the receiver stalls, the result register holds and the stage before it
// fills; s_ready falls only when both are full, so nothing is lost.
// Reset (aresetn low, synchronous) clears the counter, the pipeline and one
// valid flag per context; an unwritten context reads as its reset value, so
// there is no clearing pass and items are taken right after reset.
// The APB port holds tmsi_base at address 0; write it only while idle.
module ue_attach_paging_table
    import uapt_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  uapt_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output uapt_out_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

`include "ue_attach_paging_table_macros.svh"

    uapt_ctx_t             ctx_mem [UE_COUNT];
    logic [UE_COUNT-1:0]   ent_vld_reg;
    uapt_ctx_t             rd_ctx_reg;
    logic                  rd_vld_reg;

    logic                  byp_vld_reg;
    logic [UE_IDX_W-1:0]   byp_idx_reg;
    uapt_ctx_t             byp_ctx_reg;

    uapt_in_t              in_reg;
    logic                  s1_vld_reg;
    logic                  s1_vld_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    uapt_out_t             m_data_reg;
    uapt_out_t             m_data_next;

    logic [TIME_W-1:0]     now_ms_reg;
    logic [TIME_W-1:0]     now_ms_next;
    logic [TMSI_W-1:0]     tmsi_base_reg;

    logic                  s_fire;
    logic                  s1_fire;
    logic                  in_range;
    logic [UE_IDX_W-1:0]   s_addr;
    logic [UE_IDX_W-1:0]   s1_addr;
    logic                  wr_en;
    logic                  cfg_wr;

    uapt_ctx_t             cur;
    uapt_ctx_t             ctx_next;
    logic [TIME_W:0]       dl_sum;
    logic [TIME_W-1:0]     dl_sat;

    assign s_addr   = s_data.ue_index[UE_IDX_W-1:0];
    assign s1_addr  = in_reg.ue_index[UE_IDX_W-1:0];
    assign in_range = {1'b0, in_reg.ue_index} < 9'(UE_COUNT);

    assign s1_fire = s1_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_vld_reg || s1_fire;
    assign s_fire  = s_valid && s_ready;
    assign wr_en   = s1_fire && in_range && (action_t'(in_reg.action) != ACT_TICK);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_TMSI_BASE_ADDR);
    assign prdata = (paddr == REG_TMSI_BASE_ADDR) ?
                    CFG_DATA_W'(tmsi_base_reg) : '0;

    // context memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ctx_mem[s1_addr] <= ctx_next;
        end
        if (s_fire) begin
            rd_ctx_reg <= ctx_mem[s_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
            byp_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                ent_vld_reg[s1_addr] <= 1'b1;
                byp_vld_reg          <= 1'b1;
            end
            if (s_fire) begin
                rd_vld_reg <= ent_vld_reg[s_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            byp_idx_reg <= s1_addr;
            byp_ctx_reg <= ctx_next;
        end
        if (s_fire) begin
            in_reg <= s_data;
        end
        if (s1_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
            now_ms_reg    <= '0;
            tmsi_base_reg <= TMSI_BASE_RESET;
        end else begin
            s1_vld_reg  <= s1_vld_next;
            m_valid_reg <= m_valid_next;
            now_ms_reg  <= now_ms_next;
            if (cfg_wr) begin
                tmsi_base_reg <= pwdata[TMSI_W-1:0];
            end
        end
    end

    always_comb begin
        s1_vld_next  = s_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_vld_reg);
        m_valid_next = s1_fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        now_ms_next  = now_ms_reg;
        if (s1_fire && (action_t'(in_reg.action) == ACT_TICK) && (now_ms_reg != '1)) begin
            now_ms_next = now_ms_reg + TIME_W'(1);
        end
    end

    // context update for the beat in the input register
    always_comb begin
        if (byp_vld_reg && (byp_idx_reg == s1_addr)) begin
            cur = byp_ctx_reg;
        end else if (rd_vld_reg) begin
            cur = rd_ctx_reg;
        end else begin
            cur = CTX_RESET;
        end

        ctx_next = cur;
        dl_sum   = {1'b0, now_ms_reg} + (TIME_W + 1)'(cur.timeout);
        dl_sat   = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

        m_data_next = '0;
        m_data_next.out_ue_index = in_reg.ue_index;

        case (action_t'(in_reg.action))
            ACT_INIT: begin
                ctx_next.timeout = in_reg.timeout_ms;
            end
            ACT_SERVICE: begin
                if (cur.phase != PH_CONN) begin
                    if (in_reg.msg_valid) begin
                        if (in_reg.msg_id == MSG_CONN_RESP) begin
                            if (cur.phase == PH_IDLE && cur.short_id == '0 &&
                                in_reg.msg_bitmask == BM_RAND) begin
                                ctx_next.short_id = in_reg.msg_s_tmsi;
                                ctx_next.phase    = PH_REG;
                                ctx_next.deadline = dl_sat;
                            end else if (cur.phase == PH_IDLE &&
                                         in_reg.msg_bitmask == BM_SHORT) begin
                                ctx_next.phase = PH_CONN;
                            end
                        end else if (in_reg.msg_id == MSG_PAGING) begin
                            if (in_reg.msg_s_tmsi == cur.short_id) begin
                                ctx_next.pending = 1'b1;
                                if (cur.phase == PH_REG) begin
                                    ctx_next.phase    = PH_IDLE;
                                    ctx_next.deadline = '0;
                                end
                            end
                        end
                    end
                    if (ctx_next.phase == PH_REG && ctx_next.deadline != '0 &&
                        now_ms_reg >= ctx_next.deadline) begin
                        ctx_next.phase    = PH_IDLE;
                        ctx_next.pending  = 1'b0;
                        ctx_next.deadline = '0;
                    end
                end
            end
            ACT_POLL: begin
                if (cur.phase == PH_IDLE && cur.pending) begin
                    ctx_next.pending            = 1'b0;
                    m_data_next.request_valid   = 1'b1;
                    m_data_next.request_tmsi    = tmsi_base_reg + TMSI_W'(in_reg.ue_index);
                    if (cur.short_id != '0) begin
                        m_data_next.request_reattach = 1'b1;
                        m_data_next.request_s_tmsi   = cur.short_id;
                    end
                end
            end
            default: begin
            end
        endcase

        if (in_range) begin
            m_data_next.ue_phase      = ctx_next.phase;
            m_data_next.phase_changed = ctx_next.phase != cur.phase;
        end else begin
            m_data_next.request_valid    = 1'b0;
            m_data_next.request_reattach = 1'b0;
            m_data_next.request_s_tmsi   = '0;
            m_data_next.request_tmsi     = '0;
        end
    end

    `UAPT_ASSERT_NEXT(a_s1_to_out, s1_fire, m_valid)
    `UAPT_ASSERT_NEXT(a_s1_hold, s1_vld_reg && !s1_fire, s1_vld_reg)
    `UAPT_ASSERT_NOW(a_req_idle, m_valid && m_data.request_valid, m_data.ue_phase == PH_IDLE && !m_data.phase_changed)
    `UAPT_ASSERT_NOW(a_noreq_zero, m_valid && !m_data.request_valid, !m_data.request_reattach && m_data.request_s_tmsi == '0 && m_data.request_tmsi == '0)

endmodule
